>>> rtl/core/opr_pkg.sv
// Types, token codes and character constants for the operator and punctuator recognizer.
package opr_pkg;

   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [7:0] CH_NL     = 8'h0A;
   localparam logic [7:0] CH_BANG   = 8'h21;
   localparam logic [7:0] CH_HASH   = 8'h23;
   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_PCT    = 8'h25;
   localparam logic [7:0] CH_AMP    = 8'h26;
   localparam logic [7:0] CH_LPAR   = 8'h28;
   localparam logic [7:0] CH_RPAR   = 8'h29;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_DOT    = 8'h2E;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_COLON  = 8'h3A;
   localparam logic [7:0] CH_SEMI   = 8'h3B;
   localparam logic [7:0] CH_LT     = 8'h3C;
   localparam logic [7:0] CH_EQ     = 8'h3D;
   localparam logic [7:0] CH_GT     = 8'h3E;
   localparam logic [7:0] CH_QUEST  = 8'h3F;
   localparam logic [7:0] CH_AT     = 8'h40;
   localparam logic [7:0] CH_LBRK   = 8'h5B;
   localparam logic [7:0] CH_RBRK   = 8'h5D;
   localparam logic [7:0] CH_CARET  = 8'h5E;
   localparam logic [7:0] CH_LBRC   = 8'h7B;
   localparam logic [7:0] CH_BAR    = 8'h7C;
   localparam logic [7:0] CH_RBRC   = 8'h7D;
   localparam logic [7:0] CH_TILDE  = 8'h7E;

   typedef enum logic [5:0] {
      KIND_INVALID = 6'd0, KIND_END, KIND_QUEST, KIND_HASH, KIND_HASH2, KIND_AT,
      KIND_BANG, KIND_NE, KIND_DOLLAR, KIND_LPAR, KIND_RPAR, KIND_STAR,
      KIND_STAR_EQ, KIND_CMT_END, KIND_COMMA, KIND_PLUS, KIND_INC, KIND_PLUS_EQ,
      KIND_MINUS, KIND_DEC, KIND_MINUS_EQ, KIND_ARROW, KIND_DOT, KIND_DOT2,
      KIND_DOT3, KIND_SLASH, KIND_CMT_LINE, KIND_CMT_BLOCK, KIND_SLASH_EQ,
      KIND_PCT, KIND_PCT_EQ, KIND_COLON, KIND_SEMI, KIND_LT, KIND_SHL,
      KIND_SHL_EQ, KIND_LE, KIND_CMP3, KIND_CARET, KIND_CARET_EQ, KIND_BAR,
      KIND_BAR2, KIND_BAR_EQ, KIND_AMP, KIND_AMP2, KIND_AMP_EQ, KIND_EQ,
      KIND_EQ2, KIND_GT, KIND_SHR, KIND_SHR_EQ, KIND_GE, KIND_LBRK, KIND_SLICE,
      KIND_RBRK, KIND_LBRC, KIND_RBRC, KIND_TILDE, KIND_NL
   } kind_type;

   typedef struct packed {
      logic [7:0] first_char;
      logic [7:0] second_char;
      logic [7:0] third_char;
   } req_type;

   typedef struct packed {
      logic [5:0] token_kind;
      logic [1:0] token_length;
   } rsp_type;

   function automatic logic [1:0] kind_length(input kind_type kind);
      logic [1:0] len;
      case (kind)
         KIND_INVALID, KIND_END: len = 2'd0;
         KIND_QUEST, KIND_HASH, KIND_AT, KIND_BANG, KIND_DOLLAR, KIND_LPAR,
         KIND_RPAR, KIND_STAR, KIND_COMMA, KIND_PLUS, KIND_MINUS, KIND_DOT,
         KIND_SLASH, KIND_PCT, KIND_COLON, KIND_SEMI, KIND_LT, KIND_CARET,
         KIND_BAR, KIND_AMP, KIND_EQ, KIND_GT, KIND_LBRK, KIND_RBRK, KIND_LBRC,
         KIND_RBRC, KIND_TILDE, KIND_NL: len = 2'd1;
         KIND_DOT3, KIND_SHL_EQ, KIND_SHR_EQ, KIND_CMP3: len = 2'd3;
         default: len = 2'd2;
      endcase
      return len;
   endfunction

endpackage

>>> rtl/core/opr_classify.sv
// Longest-match classifier for one three-byte lookahead window.
module opr_classify (
   input  opr_pkg::req_type window,
   output opr_pkg::rsp_type token
);

   opr_pkg::kind_type kind;
   logic [7:0]        a;
   logic [7:0]        b;
   logic [7:0]        c;

   assign a = window.first_char;
   assign b = window.second_char;
   assign c = window.third_char;

   always_comb begin
      case (a)
         opr_pkg::CH_NUL:    kind = opr_pkg::KIND_END;
         opr_pkg::CH_QUEST:  kind = opr_pkg::KIND_QUEST;
         opr_pkg::CH_HASH:   kind = (b == opr_pkg::CH_HASH) ? opr_pkg::KIND_HASH2
                                                           : opr_pkg::KIND_HASH;
         opr_pkg::CH_AT:     kind = opr_pkg::KIND_AT;
         opr_pkg::CH_BANG:   kind = (b == opr_pkg::CH_EQ) ? opr_pkg::KIND_NE
                                                         : opr_pkg::KIND_BANG;
         opr_pkg::CH_DOLLAR: kind = opr_pkg::KIND_DOLLAR;
         opr_pkg::CH_LPAR:   kind = opr_pkg::KIND_LPAR;
         opr_pkg::CH_RPAR:   kind = opr_pkg::KIND_RPAR;
         opr_pkg::CH_STAR: begin
            if (b == opr_pkg::CH_EQ) kind = opr_pkg::KIND_STAR_EQ;
            else if (b == opr_pkg::CH_SLASH) kind = opr_pkg::KIND_CMT_END;
            else kind = opr_pkg::KIND_STAR;
         end
         opr_pkg::CH_COMMA:  kind = opr_pkg::KIND_COMMA;
         opr_pkg::CH_PLUS: begin
            if (b == opr_pkg::CH_PLUS) kind = opr_pkg::KIND_INC;
            else if (b == opr_pkg::CH_EQ) kind = opr_pkg::KIND_PLUS_EQ;
            else kind = opr_pkg::KIND_PLUS;
         end
         opr_pkg::CH_MINUS: begin
            if (b == opr_pkg::CH_MINUS) kind = opr_pkg::KIND_DEC;
            else if (b == opr_pkg::CH_EQ) kind = opr_pkg::KIND_MINUS_EQ;
            else if (b == opr_pkg::CH_GT) kind = opr_pkg::KIND_ARROW;
            else kind = opr_pkg::KIND_MINUS;
         end
         opr_pkg::CH_DOT: begin
            if (b != opr_pkg::CH_DOT) kind = opr_pkg::KIND_DOT;
            else if (c == opr_pkg::CH_DOT) kind = opr_pkg::KIND_DOT3;
            else kind = opr_pkg::KIND_DOT2;
         end
         opr_pkg::CH_SLASH: begin
            if (b == opr_pkg::CH_EQ) kind = opr_pkg::KIND_SLASH_EQ;
            else if (b == opr_pkg::CH_SLASH) kind = opr_pkg::KIND_CMT_LINE;
            else if (b == opr_pkg::CH_STAR) kind = opr_pkg::KIND_CMT_BLOCK;
            else kind = opr_pkg::KIND_SLASH;
         end
         opr_pkg::CH_PCT:    kind = (b == opr_pkg::CH_EQ) ? opr_pkg::KIND_PCT_EQ
                                                         : opr_pkg::KIND_PCT;
         opr_pkg::CH_COLON:  kind = opr_pkg::KIND_COLON;
         opr_pkg::CH_SEMI:   kind = opr_pkg::KIND_SEMI;
         opr_pkg::CH_LT: begin
            if (b == opr_pkg::CH_LT) begin
               kind = (c == opr_pkg::CH_EQ) ? opr_pkg::KIND_SHL_EQ : opr_pkg::KIND_SHL;
            end else if (b == opr_pkg::CH_EQ) begin
               kind = (c == opr_pkg::CH_GT) ? opr_pkg::KIND_CMP3 : opr_pkg::KIND_LE;
            end else begin
               kind = opr_pkg::KIND_LT;
            end
         end
         opr_pkg::CH_CARET:  kind = (b == opr_pkg::CH_EQ) ? opr_pkg::KIND_CARET_EQ
                                                         : opr_pkg::KIND_CARET;
         opr_pkg::CH_BAR: begin
            if (b == opr_pkg::CH_BAR) kind = opr_pkg::KIND_BAR2;
            else if (b == opr_pkg::CH_EQ) kind = opr_pkg::KIND_BAR_EQ;
            else kind = opr_pkg::KIND_BAR;
         end
         opr_pkg::CH_AMP: begin
            if (b == opr_pkg::CH_AMP) kind = opr_pkg::KIND_AMP2;
            else if (b == opr_pkg::CH_EQ) kind = opr_pkg::KIND_AMP_EQ;
            else kind = opr_pkg::KIND_AMP;
         end
         opr_pkg::CH_EQ:     kind = (b == opr_pkg::CH_EQ) ? opr_pkg::KIND_EQ2
                                                         : opr_pkg::KIND_EQ;
         opr_pkg::CH_GT: begin
            if (b == opr_pkg::CH_GT) begin
               kind = (c == opr_pkg::CH_EQ) ? opr_pkg::KIND_SHR_EQ : opr_pkg::KIND_SHR;
            end else if (b == opr_pkg::CH_EQ) begin
               kind = opr_pkg::KIND_GE;
            end else begin
               kind = opr_pkg::KIND_GT;
            end
         end
         opr_pkg::CH_LBRK:   kind = (b == opr_pkg::CH_RBRK) ? opr_pkg::KIND_SLICE
                                                           : opr_pkg::KIND_LBRK;
         opr_pkg::CH_RBRK:   kind = opr_pkg::KIND_RBRK;
         opr_pkg::CH_LBRC:   kind = opr_pkg::KIND_LBRC;
         opr_pkg::CH_RBRC:   kind = opr_pkg::KIND_RBRC;
         opr_pkg::CH_TILDE:  kind = opr_pkg::KIND_TILDE;
         opr_pkg::CH_NL:     kind = opr_pkg::KIND_NL;
         default:            kind = opr_pkg::KIND_INVALID;
      endcase
   end

   assign token.token_kind   = kind;
   assign token.token_length = opr_pkg::kind_length(kind);

endmodule

>>> rtl/core/operator_punctuator_recognizer_top.sv
// Top level: input register, classifier and result register of the recognizer.
// An accepted item passes the input register, then the result register, to rsp_valid.
// Throughput: one item per cycle while rsp_ready is high. The input register refills
// when empty or the result register advances; req_ready drops only with both full.
// The classifier between the registers is the only logic on the item path.
// Reset clears both valid flags; payload registers are not reset.
module operator_punctuator_recognizer_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  opr_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output opr_pkg::rsp_type rsp_data
);

   logic             in_valid_ff;
   logic             in_valid_in;
   opr_pkg::req_type in_data_ff;
   opr_pkg::req_type in_data_in;
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   opr_pkg::rsp_type rsp_data_ff;
   opr_pkg::rsp_type rsp_data_in;
   opr_pkg::rsp_type class_rsp;
   logic             advance;

   opr_classify u_classify (
      .window (in_data_ff),
      .token  (class_rsp)
   );

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in  = req_ready ? req_valid : in_valid_ff;
      in_data_in   = (req_valid && req_ready) ? req_data : in_data_ff;
      rsp_valid_in = advance ? in_valid_ff : rsp_valid_ff;
      rsp_data_in  = (advance && in_valid_ff) ? class_rsp : rsp_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_data_ff  <= in_data_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

>>> rtl/core/opr_checker.sv
// Port-level checks for the recognizer, bound to the top level.
module opr_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input opr_pkg::rsp_type rsp_data
);

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled item changed");

   a_len_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_data.token_length == 2'd0) ==
                     ((rsp_data.token_kind == opr_pkg::KIND_INVALID) ||
                      (rsp_data.token_kind == opr_pkg::KIND_END))))
      else $error("length does not match kind");

   a_kind_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.token_kind <= opr_pkg::KIND_NL))
      else $error("kind out of range");

   a_free_flow: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with empty output");

endmodule

bind operator_punctuator_recognizer_top opr_checker u_opr_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
